// ===== sv/ompc_pkg.sv =====
// Shared types and constants for the optical Morse pulse classifier.
// No dependencies; imported by optical_morse_pulse_classifier_unit.
package ompc_pkg;

	localparam int THR_W     = 12;
	localparam int LEN_W     = 7;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;

	// result kinds (travel on m_tuser)
	localparam logic [1:0] EV_DOT  = 2'd0;
	localparam logic [1:0] EV_DASH = 2'd1;
	localparam logic [1:0] EV_GAP  = 2'd2;
	localparam logic [1:0] EV_END  = 2'd3;

	// message end status
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_DOUBLE = 2'd1;
	localparam logic [1:0] ST_LONG   = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THR_BASE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DASH_MIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LTR_GAP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MSG_TMO  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ADAPT    = 3'd5;

	// register reset values
	localparam logic [THR_W-1:0] RST_THR_BASE = 12'd500;
	localparam logic [CFG_W-1:0] RST_DEBOUNCE = 16'd50;
	localparam logic [CFG_W-1:0] RST_DASH_MIN = 16'd175;
	localparam logic [CFG_W-1:0] RST_LTR_GAP  = 16'd500;
	localparam logic [CFG_W-1:0] RST_MSG_TMO  = 16'd3000;
	localparam logic [CFG_W-1:0] RST_ADAPT    = 16'd5000;

	// fixed limits
	localparam int PRIME_FLOOR = 100;
	localparam int THR_MIN     = 50;
	localparam int THR_MAX     = 3000;
	localparam int THR_SAT     = 4095;
	localparam int RATE_MS     = 5;
	localparam int COUNT_MAX   = 127;

	typedef logic [1:0] ev_kind_t;
	typedef logic [1:0] msg_status_t;

endpackage

// ===== sv/optical_morse_pulse_classifier_unit.sv =====
// Optical Morse pulse classifier top level: three-sample averaging, adaptive
// threshold, debounced dot/dash/gap detection and message end reporting.
// Depends on ompc_pkg.
//
// Results: a request passes the input register, the averaging stage and the
// event stage, and any result it yields is written into the result register.
// Throughput: one request per cycle; the whole pipe holds only while a result
// waits and m_tready is low.
// Reset (arst_n low, asynchronous): registers take their default values,
// the block returns to the unprimed state and the pipe empties.
module optical_morse_pulse_classifier_unit
	import ompc_pkg::*;
#(
	parameter int SAMPLE_BITS = 12,
	parameter int MAX_SYMBOLS = 50,
	localparam int IN_W       = 32 + 3 * SAMPLE_BITS,
	localparam int IN_BYTES   = (IN_W + 7) / 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration write port
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	// input stream
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [8*IN_BYTES-1:0]   s_tdata,  // now_ms, sample_a, sample_b, sample_c, zero pad
	// result stream
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [1:0]              m_tuser,  // event_kind
	output logic [23:0]             m_tdata   // message_status, symbol_count, threshold_now, pad
);

	localparam int AVG_W    = SAMPLE_BITS;
	localparam int SUM_W    = SAMPLE_BITS + 2;
	localparam int DIV3_SH  = SUM_W + 1;
	localparam int DIV3_MUL = ((1 << DIV3_SH) + 2) / 3;
	localparam int P3_W     = SUM_W + DIV3_SH;
	localparam int Y_W      = ((THR_W + 2) > AVG_W ? (THR_W + 2) : AVG_W) + 1;
	localparam int DIV5_SH  = Y_W + 2;
	localparam int DIV5_MUL = ((1 << DIV5_SH) + 4) / 5;
	localparam int P5_W     = Y_W + DIV5_SH;

	// configuration registers
	logic [THR_W-1:0] thr_base_q;
	logic [CFG_W-1:0] debounce_q, dash_min_q, ltr_gap_q, msg_tmo_q, adapt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_base_q <= RST_THR_BASE;
			debounce_q <= RST_DEBOUNCE;
			dash_min_q <= RST_DASH_MIN;
			ltr_gap_q  <= RST_LTR_GAP;
			msg_tmo_q  <= RST_MSG_TMO;
			adapt_q    <= RST_ADAPT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THR_BASE: thr_base_q <= cfg_data[THR_W-1:0];
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_DASH_MIN: dash_min_q <= cfg_data;
				REG_LTR_GAP:  ltr_gap_q  <= cfg_data;
				REG_MSG_TMO:  msg_tmo_q  <= cfg_data;
				REG_ADAPT:    adapt_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// the pipe moves whenever the result register is free or being drained
	logic adv;
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	// stage 1: input register
	logic             v_s1;
	logic [31:0]      now_s1;
	logic [AVG_W-1:0] a_s1, b_s1, c_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (adv && s_tvalid) begin
			now_s1 <= s_tdata[31:0];
			a_s1   <= s_tdata[32 +: AVG_W];
			b_s1   <= s_tdata[32 + AVG_W +: AVG_W];
			c_s1   <= s_tdata[32 + 2 * AVG_W +: AVG_W];
		end
	end

	// stage 2: average by reciprocal multiply
	logic [SUM_W-1:0] sum3;
	logic [P3_W-1:0]  prod3;
	logic             v_s2;
	logic [31:0]      now_s2;
	logic [AVG_W-1:0] avg_s2;

	assign sum3  = SUM_W'(a_s1) + SUM_W'(b_s1) + SUM_W'(c_s1);
	assign prod3 = P3_W'(sum3) * P3_W'(DIV3_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			now_s2 <= now_s1;
			avg_s2 <= AVG_W'(prod3 >> DIV3_SH);
		end
	end

	// classifier state
	logic             primed_q, light_q, in_msg_q, prev_gap_q, dbl_gap_q;
	logic [THR_W-1:0] thr_q;
	logic [31:0]      last_sample_q, last_adapt_q, last_change_q;
	logic [LEN_W-1:0] len_q;

	// event logic
	logic [Y_W-1:0]   avg_y, y5, q5, thr_adapt_y;
	logic [P5_W-1:0]  prod5;
	logic [THR_W-1:0] prime_thr, thr_new;
	logic [31:0]      d_sample, d_adapt, dur;
	logic             rate_ok, adapt, cur, change, deb_ok;
	logic             ev_pulse, ev_gap, ev_end, emit;
	logic [LEN_W-1:0] len_inc;
	ev_kind_t         kind_n;
	msg_status_t      status_n;
	logic [LEN_W-1:0] count_n;

	assign avg_y = Y_W'(avg_s2);
	assign y5    = Y_W'({thr_q, 2'b00}) + avg_y;
	assign prod5 = P5_W'(y5) * P5_W'(DIV5_MUL);
	assign q5    = Y_W'(prod5 >> DIV5_SH);

	always_comb begin
		if (q5 < Y_W'(THR_MIN))      thr_adapt_y = Y_W'(THR_MIN);
		else if (q5 > Y_W'(THR_MAX)) thr_adapt_y = Y_W'(THR_MAX);
		else                         thr_adapt_y = q5;
	end

	always_comb begin
		if (avg_y < Y_W'(PRIME_FLOOR))   prime_thr = thr_base_q;
		else if (avg_y > Y_W'(THR_SAT))  prime_thr = THR_W'(THR_SAT);
		else                             prime_thr = THR_W'(avg_y);
	end

	assign d_sample = now_s2 - last_sample_q;
	assign d_adapt  = now_s2 - last_adapt_q;
	assign dur      = now_s2 - last_change_q;
	assign rate_ok  = d_sample >= 32'(RATE_MS);
	assign adapt    = d_adapt > 32'(adapt_q);
	assign thr_new  = adapt ? THR_W'(thr_adapt_y) : thr_q;
	assign cur      = avg_y > Y_W'(thr_new);
	assign change   = cur != light_q;
	assign deb_ok   = dur >= 32'(debounce_q);
	assign len_inc  = (len_q < LEN_W'(COUNT_MAX)) ? len_q + LEN_W'(1) : len_q;

	// an accepted, primed request that meets the sample rate reaches the detector
	logic live;
	assign live     = v_s2 && primed_q && rate_ok;
	assign ev_pulse = live && change && deb_ok && light_q;
	assign ev_gap   = live && change && deb_ok && !light_q && in_msg_q
		&& (dur >= 32'(ltr_gap_q));
	// a debounced transition moves the change time to now, event or not, so the
	// timeout can only fire when the light level holds
	assign ev_end   = live && !change && in_msg_q && (dur > 32'(msg_tmo_q));
	assign emit     = ev_pulse || ev_gap || ev_end;

	always_comb begin
		kind_n   = EV_END;
		status_n = ST_OK;
		count_n  = len_q;
		if (ev_pulse) begin
			kind_n  = (dur >= 32'(dash_min_q)) ? EV_DASH : EV_DOT;
			count_n = len_inc;
		end else if (ev_gap) begin
			kind_n  = EV_GAP;
			count_n = len_inc;
		end else if (dbl_gap_q) begin
			status_n = ST_DOUBLE;
		end else if (len_q > LEN_W'(MAX_SYMBOLS)) begin
			status_n = ST_LONG;
		end
	end

	logic step;
	assign step = adv && v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q      <= 1'b0;
			thr_q         <= '0;
			last_sample_q <= '0;
			last_adapt_q  <= '0;
			last_change_q <= '0;
			light_q       <= 1'b0;
			in_msg_q      <= 1'b0;
			len_q         <= '0;
			prev_gap_q    <= 1'b0;
			dbl_gap_q     <= 1'b0;
		end else if (step) begin
			if (!primed_q) begin
				primed_q      <= 1'b1;
				thr_q         <= prime_thr;
				last_change_q <= now_s2;
			end else if (rate_ok) begin
				last_sample_q <= now_s2;
				thr_q         <= thr_new;
				if (adapt) last_adapt_q <= now_s2;
				if (change && deb_ok) begin
					last_change_q <= now_s2;
					light_q       <= cur;
				end
				if (ev_pulse) begin
					len_q      <= len_inc;
					prev_gap_q <= 1'b0;
					in_msg_q   <= 1'b1;
				end else if (ev_gap) begin
					len_q      <= len_inc;
					prev_gap_q <= 1'b1;
					dbl_gap_q  <= dbl_gap_q || prev_gap_q;
				end else if (ev_end) begin
					in_msg_q   <= 1'b0;
					len_q      <= '0;
					prev_gap_q <= 1'b0;
					dbl_gap_q  <= 1'b0;
				end
			end
		end
	end

	// result register
	ev_kind_t         kind_q;
	msg_status_t      status_q;
	logic [LEN_W-1:0] count_q;
	logic [THR_W-1:0] thr_out_q;
	logic             out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (adv) out_v_q <= step && emit;
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			kind_q    <= kind_n;
			status_q  <= status_n;
			count_q   <= count_n;
			thr_out_q <= thr_new;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {3'b000, thr_out_q, count_q, status_q};

	// nothing leaves the priming request
	a_prime_silent: assert property (@(posedge clk) disable iff (!arst_n)
		step && !primed_q |=> !m_tvalid)
		else $error("priming request produced a result");

	// adapted threshold stays inside its clamp window
	a_thr_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		step && primed_q && rate_ok && adapt
		|=> thr_q >= THR_W'(THR_MIN) && thr_q <= THR_W'(THR_MAX))
		else $error("adapted threshold out of range");

	// only a message end carries a status
	a_status_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != EV_END |-> m_tdata[1:0] == ST_OK)
		else $error("status set on a symbol result");

	// a message end clears the message state
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && ev_end |=> !in_msg_q && len_q == '0 && !prev_gap_q && !dbl_gap_q)
		else $error("message state kept after message end");

endmodule
